[rtl/aob_pkg.sv]
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types, constants and helpers of the alpha over blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int CH_W      = 16;
    localparam int DEN_W     = 31;
    localparam int NUM_W     = 46;
    localparam int DIV_STEPS = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CH_W-1:0] MAX8  = 16'd255;
    localparam logic [CH_W-1:0] MAX16 = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ENABLE = 2'd1;

    // lane 0 alpha, 1 red, 2 green, 3 blue
    typedef logic [3:0][CH_W-1:0] t_pixel;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [CH_W-1:0]  lq;
    } t_lane;

    typedef struct packed {
        t_lane [3:0]      lane;
        logic [DEN_W-1:0] den;
        logic             mode;
        logic             bypass;
        t_pixel           pix;
    } t_div_item;

    function automatic logic [CH_W-1:0] chan_max(input logic mode);
        return mode ? MAX16 : MAX8;
    endfunction

endpackage

[rtl/aob_front.sv]
// ----------------------------------------------------------------------------
// aob_front
// Saturation, alpha products and numerator sums ahead of the dividers.
// ----------------------------------------------------------------------------
module aob_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_depth_mode,
    input  logic               i_blend_enable,
    input  aob_pkg::t_pixel    i_src,
    input  aob_pkg::t_pixel    i_drawn,
    output logic               o_valid,
    output aob_pkg::t_div_item o_item
);

    // stage 1: saturate, pick pass-through pixel
    logic [15:0]     n_s1_max;
    aob_pkg::t_pixel n_s1_src;
    aob_pkg::t_pixel n_s1_drawn;
    logic            n_s1_bypass;

    logic            r_s1_valid;
    logic            r_s1_mode;
    logic            r_s1_bypass;
    aob_pkg::t_pixel r_s1_src;
    aob_pkg::t_pixel r_s1_drawn;
    aob_pkg::t_pixel r_s1_pix;

    always_comb begin
        n_s1_max = aob_pkg::chan_max(i_depth_mode);
        for (int c = 0; c < 4; c++) begin
            n_s1_src[c]   = (i_src[c] > n_s1_max) ? n_s1_max : i_src[c];
            n_s1_drawn[c] = (i_drawn[c] > n_s1_max) ? n_s1_max : i_drawn[c];
        end
        n_s1_bypass = !i_blend_enable || (n_s1_drawn[0] == 16'd0);
    end

    // stage 2: alpha products
    logic [15:0]     n_s2_max;
    logic [16:0]     n_s2_asum;
    logic [31:0]     n_s2_paa;
    logic [31:0]     n_s2_sm;
    logic [30:0]     n_s2_w1;
    logic [31:0]     n_s2_w0;

    logic            r_s2_valid;
    logic            r_s2_mode;
    logic            r_s2_bypass;
    aob_pkg::t_pixel r_s2_src;
    aob_pkg::t_pixel r_s2_drawn;
    aob_pkg::t_pixel r_s2_pix;
    logic [31:0]     r_s2_paa;
    logic [31:0]     r_s2_sm;
    logic [30:0]     r_s2_w1;
    logic [30:0]     r_s2_w0;

    always_comb begin
        n_s2_max  = aob_pkg::chan_max(r_s1_mode);
        n_s2_asum = {1'b0, r_s1_src[0]} + {1'b0, r_s1_drawn[0]};
        n_s2_paa  = r_s1_src[0] * r_s1_drawn[0];
        if (r_s1_mode) begin
            n_s2_sm = {n_s2_asum, 15'b0};
            n_s2_w1 = {r_s1_drawn[0], 15'b0};
        end else begin
            n_s2_sm = {7'b0, n_s2_asum, 8'b0} - {15'b0, n_s2_asum};
            n_s2_w1 = {7'b0, r_s1_drawn[0], 8'b0} - {15'b0, r_s1_drawn[0]};
        end
        n_s2_w0 = r_s1_src[0] * (n_s2_max - r_s1_drawn[0]);
    end

    // stage 3: combined alpha and weighted colors
    logic [31:0]     n_s3_den;
    logic [46:0]     n_s3_pd [1:3];
    logic [46:0]     n_s3_ps [1:3];

    logic            r_s3_valid;
    logic            r_s3_mode;
    logic            r_s3_bypass;
    aob_pkg::t_pixel r_s3_pix;
    logic [30:0]     r_s3_den;
    logic [45:0]     r_s3_pd [1:3];
    logic [45:0]     r_s3_ps [1:3];

    always_comb begin
        n_s3_den = r_s2_sm - r_s2_paa;
        for (int c = 1; c < 4; c++) begin
            n_s3_pd[c] = r_s2_drawn[c] * r_s2_w1;
            n_s3_ps[c] = r_s2_src[c] * r_s2_w0;
        end
    end

    // stage 4: rounded dividends, output alpha by shift or divide by 255
    logic [15:0]        n_s4_max;
    logic [45:0]        n_s4_num [0:3];
    logic [16:0]        n_s4_a8;
    logic [15:0]        n_s4_alpha;
    aob_pkg::t_div_item n_s4_item;

    logic               r_s4_valid;
    aob_pkg::t_div_item r_s4_item;

    always_comb begin
        n_s4_max    = aob_pkg::chan_max(r_s3_mode);
        n_s4_num[0] = {15'b0, r_s3_den} + {31'b0, n_s4_max[15:1]};
        // x / 255 as (x + (x >> 8) + 1) >> 8, exact for x up to 65534
        n_s4_a8     = {1'b0, n_s4_num[0][15:0]} + {9'b0, n_s4_num[0][15:8]} + 17'd1;
        n_s4_alpha  = r_s3_mode ? n_s4_num[0][30:15] : {7'b0, n_s4_a8[16:8]};
        for (int c = 1; c < 4; c++) begin
            n_s4_num[c] = r_s3_pd[c] + r_s3_ps[c] + {16'b0, r_s3_den[30:1]};
        end
        n_s4_item.lane[0].rem = '0;
        n_s4_item.lane[0].lq  = n_s4_alpha;
        for (int c = 1; c < 4; c++) begin
            n_s4_item.lane[c].rem = {1'b0, n_s4_num[c][45:16]};
            n_s4_item.lane[c].lq  = n_s4_num[c][15:0];
        end
        n_s4_item.den    = r_s3_den;
        n_s4_item.mode   = r_s3_mode;
        n_s4_item.bypass = r_s3_bypass;
        n_s4_item.pix    = r_s3_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mode   <= i_depth_mode;
            r_s1_bypass <= n_s1_bypass;
            r_s1_src    <= n_s1_src;
            r_s1_drawn  <= n_s1_drawn;
            r_s1_pix    <= i_blend_enable ? n_s1_src : n_s1_drawn;

            r_s2_mode   <= r_s1_mode;
            r_s2_bypass <= r_s1_bypass;
            r_s2_src    <= r_s1_src;
            r_s2_drawn  <= r_s1_drawn;
            r_s2_pix    <= r_s1_pix;
            r_s2_paa    <= n_s2_paa;
            r_s2_sm     <= n_s2_sm;
            r_s2_w1     <= n_s2_w1;
            r_s2_w0     <= n_s2_w0[30:0];

            r_s3_mode   <= r_s2_mode;
            r_s3_bypass <= r_s2_bypass;
            r_s3_pix    <= r_s2_pix;
            r_s3_den    <= n_s3_den[30:0];
            for (int c = 1; c < 4; c++) begin
                r_s3_pd[c] <= n_s3_pd[c][45:0];
                r_s3_ps[c] <= n_s3_ps[c][45:0];
            end

            r_s4_item   <= n_s4_item;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_item  = r_s4_item;

endmodule

[rtl/aob_div_pipe.sv]
// ----------------------------------------------------------------------------
// aob_div_pipe
// Pipelined restoring divider, three color lanes, one quotient bit per stage.
// The alpha lane is already final and rides along unchanged.
// ----------------------------------------------------------------------------
module aob_div_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  aob_pkg::t_div_item i_item,
    output logic               o_valid,
    output aob_pkg::t_div_item o_item
);

    localparam int Steps = aob_pkg::DIV_STEPS;

    function automatic aob_pkg::t_lane lane_step(input aob_pkg::t_lane l,
                                                 input logic [30:0] d);
        logic [31:0]    t;
        logic [31:0]    diff;
        aob_pkg::t_lane r;
        t    = {l.rem, l.lq[15]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            r.rem = diff[30:0];
            r.lq  = {l.lq[14:0], 1'b1};
        end else begin
            r.rem = t[30:0];
            r.lq  = {l.lq[14:0], 1'b0};
        end
        return r;
    endfunction

    logic [Steps-1:0]   r_valid;
    aob_pkg::t_div_item r_item [Steps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[Steps-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        aob_pkg::t_div_item prev;
        aob_pkg::t_div_item n_item;

        if (k == 0) begin : g_first
            assign prev = i_item;
        end else begin : g_rest
            assign prev = r_item[k-1];
        end

        always_comb begin
            n_item = prev;
            for (int c = 1; c < 4; c++) begin
                n_item.lane[c] = lane_step(prev.lane[c], prev.den);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k] <= n_item;
            end
        end
    end

    assign o_valid = r_valid[Steps-1];
    assign o_item  = r_item[Steps-1];

endmodule

[rtl/aob_out_queue.sv]
// ----------------------------------------------------------------------------
// aob_out_queue
// Final clamp and pass-through select, two-entry output queue.
// ----------------------------------------------------------------------------
module aob_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  aob_pkg::t_div_item i_item,
    input  logic               i_ready,
    output logic               o_en,
    output logic               o_valid,
    output aob_pkg::t_pixel    o_pix
);

    logic [15:0]     n_max;
    aob_pkg::t_pixel n_pix;
    logic            n_push;
    logic            n_pop;

    aob_pkg::t_pixel r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;

    always_comb begin
        n_max = aob_pkg::chan_max(i_item.mode);
        for (int c = 0; c < 4; c++) begin
            n_pix[c] = (i_item.lane[c].lq > n_max) ? n_max : i_item.lane[c].lq;
        end
        if (i_item.bypass) begin
            n_pix = i_item.pix;
        end
    end

    assign o_en    = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign n_push  = i_valid && o_en;
    assign n_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (n_push) begin
                r_wr <= ~r_wr;
            end
            if (n_pop) begin
                r_rd <= ~r_rd;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 2'd1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr] <= n_pix;
        end
    end

    assign o_pix = r_mem[r_rd];

endmodule

[rtl/alpha_over_blend_pixel.sv]
// ----------------------------------------------------------------------------
// alpha_over_blend_pixel
// Straight-alpha ARGB over compositing of a drawn pixel onto a source pixel.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_ready carries one source and one drawn
//   pixel per item; output channel o_out_valid / i_out_ready carries the
//   composited pixel. The config channel (i_cfg_valid / o_cfg_ready) is
//   always ready and writes depth_mode (index 0) or blend_enable (index 1);
//   other indexes are ignored. Write it only while the pipeline is empty.
// Pipeline: 4 front stages (saturate, alpha products, color products,
//   dividends), 16 divider stages producing one quotient bit each, and the
//   output queue, in that order from input accept to o_out_valid.
// Throughput: one item per cycle while the output queue is not full, set by the fully pipelined divider lanes.
// Stall: the whole pipeline holds while the two-entry output queue is full;
//   with one result waiting, new items are still accepted.
// Reset: synchronous, clears valid bits, the queue and both config
//   registers (8-bit mode, blending off).
// ----------------------------------------------------------------------------
module alpha_over_blend_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aob_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                           i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [15:0]                    i_src_alpha,
    input  logic [15:0]                    i_src_red,
    input  logic [15:0]                    i_src_green,
    input  logic [15:0]                    i_src_blue,
    input  logic [15:0]                    i_drawn_alpha,
    input  logic [15:0]                    i_drawn_red,
    input  logic [15:0]                    i_drawn_green,
    input  logic [15:0]                    i_drawn_blue,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [15:0]                    o_res_alpha,
    output logic [15:0]                    o_res_red,
    output logic [15:0]                    o_res_green,
    output logic [15:0]                    o_res_blue
);

    logic               r_depth_mode;
    logic               r_blend_enable;

    logic               en;
    aob_pkg::t_pixel    src;
    aob_pkg::t_pixel    drawn;
    aob_pkg::t_pixel    res;
    logic               front_valid;
    aob_pkg::t_div_item front_item;
    logic               div_valid;
    aob_pkg::t_div_item div_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode   <= 1'b0;
            r_blend_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aob_pkg::CFG_DEPTH_MODE:   r_depth_mode   <= i_cfg_data;
                aob_pkg::CFG_BLEND_ENABLE: r_blend_enable <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign src   = {i_src_blue, i_src_green, i_src_red, i_src_alpha};
    assign drawn = {i_drawn_blue, i_drawn_green, i_drawn_red, i_drawn_alpha};

    assign o_in_ready = en;

    aob_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in_valid),
        .i_depth_mode   (r_depth_mode),
        .i_blend_enable (r_blend_enable),
        .i_src          (src),
        .i_drawn        (drawn),
        .o_valid        (front_valid),
        .o_item         (front_item)
    );

    aob_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    aob_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_item  (div_item),
        .i_ready (i_out_ready),
        .o_en    (en),
        .o_valid (o_out_valid),
        .o_pix   (res)
    );

    assign o_res_alpha = res[0];
    assign o_res_red   = res[1];
    assign o_res_green = res[2];
    assign o_res_blue  = res[3];

endmodule

[rtl/aob_checker.sv]
// ----------------------------------------------------------------------------
// aob_checker
// Port-level checks of the alpha over blend block, bound to the top level.
// ----------------------------------------------------------------------------
module aob_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_res_alpha,
    input logic [15:0] o_res_red,
    input logic [15:0] o_res_green,
    input logic [15:0] o_res_blue
);

    // no item survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_res_alpha)
            && $stable(o_res_red) && $stable(o_res_green) && $stable(o_res_blue))
        else $error("stalled output item changed");

    // empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // results stay within the largest channel max
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_res_alpha <= 16'd32768 && o_res_red <= 16'd32768
            && o_res_green <= 16'd32768 && o_res_blue <= 16'd32768)
        else $error("result above channel max");

endmodule

bind alpha_over_blend_pixel aob_checker u_aob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_res_alpha (o_res_alpha),
    .o_res_red   (o_res_red),
    .o_res_green (o_res_green),
    .o_res_blue  (o_res_blue)
);

[sim/alpha_over_blend_pixel_tb.sv]
// ----------------------------------------------------------------------------
// alpha_over_blend_pixel_tb
// Self-checking bench for the straight-alpha ARGB over compositor. Pixel
// pairs go in over a valid/ready channel, and each composited pixel that
// comes out is compared lane by lane with an in-bench integer model of the
// over rule. The model covers input saturation, pass-through with blending
// off, and the source taken when the drawn alpha is zero. Directed corners
// come first, then random pixel pairs under every register setting. Both
// channels stall in random bursts, and the last phase runs at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module alpha_over_blend_pixel_tb;
    import aob_pkg::*;

    localparam int LANE_A = 0;
    localparam int LANE_R = 1;
    localparam int LANE_G = 2;
    localparam int LANE_B = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 200;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic                 i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [15:0]          i_src_alpha;
    logic [15:0]          i_src_red;
    logic [15:0]          i_src_green;
    logic [15:0]          i_src_blue;
    logic [15:0]          i_drawn_alpha;
    logic [15:0]          i_drawn_red;
    logic [15:0]          i_drawn_green;
    logic [15:0]          i_drawn_blue;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b1;
    logic [15:0]          o_res_alpha;
    logic [15:0]          o_res_red;
    logic [15:0]          o_res_green;
    logic [15:0]          o_res_blue;

    t_pixel composited_q[$];
    logic   depth16 = 1'b0;
    logic   blend_on = 1'b0;
    int     idle_pct = 0;
    int     ready_hold = 0;
    int     cycle_count = 0;
    int     mismatch_count = 0;
    int     pixels_sent = 0;
    int     pixels_checked = 0;
    int     settings_run = 0;

    alpha_over_blend_pixel dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_src_alpha   (i_src_alpha),
        .i_src_red     (i_src_red),
        .i_src_green   (i_src_green),
        .i_src_blue    (i_src_blue),
        .i_drawn_alpha (i_drawn_alpha),
        .i_drawn_red   (i_drawn_red),
        .i_drawn_green (i_drawn_green),
        .i_drawn_blue  (i_drawn_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_res_alpha   (o_res_alpha),
        .o_res_red     (o_res_red),
        .o_res_green   (o_res_green),
        .o_res_blue    (o_res_blue)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_pixel mk_pixel(input logic [15:0] a, input logic [15:0] r,
                                        input logic [15:0] g, input logic [15:0] b);
        t_pixel p;
        p[LANE_A] = a;
        p[LANE_R] = r;
        p[LANE_G] = g;
        p[LANE_B] = b;
        return p;
    endfunction

    // over rule on straight alpha, rounded to nearest and clamped to the max
    function automatic t_pixel blend_over(input t_pixel src, input t_pixel drawn,
                                          input logic mode16, input logic blend);
        logic [63:0] m;
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        t_pixel      s;
        t_pixel      d;
        t_pixel      r;
        int          k;
        m = mode16 ? 64'(MAX16) : 64'(MAX8);
        for (k = 0; k < 4; k++) begin
            s[k] = (64'(src[k]) > m) ? m[15:0] : src[k];
            d[k] = (64'(drawn[k]) > m) ? m[15:0] : drawn[k];
        end
        if (!blend)
            return d;
        if (d[LANE_A] == 16'd0)
            return s;
        a0  = 64'(s[LANE_A]);
        a1  = 64'(d[LANE_A]);
        den = m * (a0 + a1) - a0 * a1;
        q   = (den + m / 2) / m;
        r[LANE_A] = (q > m) ? m[15:0] : q[15:0];
        for (k = LANE_R; k <= LANE_B; k++) begin
            num  = 64'(d[k]) * a1 * m + 64'(s[k]) * a0 * (m - a1);
            q    = (den == 64'd0) ? 64'd0 : (num + den / 2) / den;
            r[k] = (q > m) ? m[15:0] : q[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] rand_chan(input logic mode16);
        logic [15:0] m;
        m = mode16 ? MAX16 : MAX8;
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return m;
            2: return 16'($urandom_range(0, 65535));
            3: return m - 16'd1;
            default: return 16'($urandom_range(0, int'(m)));
        endcase
    endfunction

    function automatic t_pixel rand_pixel(input logic mode16);
        return mk_pixel(rand_chan(mode16), rand_chan(mode16),
                        rand_chan(mode16), rand_chan(mode16));
    endfunction

    task automatic push_pixel(input t_pixel src, input t_pixel drawn);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_src_alpha   = src[LANE_A];
        i_src_red     = src[LANE_R];
        i_src_green   = src[LANE_G];
        i_src_blue    = src[LANE_B];
        i_drawn_alpha = drawn[LANE_A];
        i_drawn_red   = drawn[LANE_R];
        i_drawn_green = drawn[LANE_G];
        i_drawn_blue  = drawn[LANE_B];
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        composited_q.push_back(blend_over(src, drawn, depth16, blend_on));
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEPTH_MODE:   depth16 = val;
            CFG_BLEND_ENABLE: blend_on = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain_pipeline;
        i_in_valid = 1'b0;
        while (composited_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic mode16, input logic blend);
        drain_pipeline();
        write_reg(CFG_DEPTH_MODE, mode16);
        write_reg(CFG_BLEND_ENABLE, blend);
        settings_run++;
    endtask

    task automatic test_reset_defaults;
        push_pixel(mk_pixel(16'd10, 16'd20, 16'd30, 16'd40),
                   mk_pixel(16'd255, 16'd0, 16'd128, 16'd255));
        push_pixel(mk_pixel(16'd255, 16'd255, 16'd255, 16'd255),
                   mk_pixel(16'hffff, 16'h0100, 16'd256, 16'h8000));
        push_pixel(mk_pixel(16'd0, 16'd0, 16'd0, 16'd0),
                   mk_pixel(16'd0, 16'd1, 16'd254, 16'd7));
    endtask

    task automatic test_spare_indexes;
        drain_pipeline();
        write_reg(CFG_SPARE_2, 1'b1);
        write_reg(CFG_SPARE_3, 1'b1);
        push_pixel(mk_pixel(16'd100, 16'd1, 16'd2, 16'd3),
                   mk_pixel(16'd50, 16'd300, 16'd200, 16'd100));
        push_pixel(mk_pixel(16'd255, 16'd9, 16'd9, 16'd9),
                   mk_pixel(16'd0, 16'd250, 16'd251, 16'd252));
    endtask

    task automatic test_passthrough_16bit;
        apply_setting(1'b1, 1'b0);
        push_pixel(mk_pixel(16'd1, 16'd2, 16'd3, 16'd4),
                   mk_pixel(16'hffff, 16'h7fff, 16'h8000, 16'h8001));
        push_pixel(mk_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                   mk_pixel(16'd0, 16'h5555, 16'h2aaa, 16'd0));
        push_pixel(mk_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff),
                   mk_pixel(16'd32767, 16'd255, 16'd256, 16'd1));
    endtask

    task automatic test_blend_8bit;
        apply_setting(1'b0, 1'b1);
        push_pixel(mk_pixel(16'd200, 16'd10, 16'd20, 16'd30),
                   mk_pixel(16'd0, 16'd255, 16'd255, 16'd255));
        push_pixel(mk_pixel(16'd128, 16'd1, 16'd2, 16'd3),
                   mk_pixel(16'd255, 16'd250, 16'd5, 16'd100));
        push_pixel(mk_pixel(16'd0, 16'd9, 16'd9, 16'd9),
                   mk_pixel(16'd77, 16'd200, 16'd100, 16'd50));
        push_pixel(mk_pixel(16'd128, 16'd255, 16'd0, 16'd128),
                   mk_pixel(16'd128, 16'd0, 16'd255, 16'd128));
        push_pixel(mk_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff),
                   mk_pixel(16'h8000, 16'hffff, 16'd0, 16'h0100));
        push_pixel(mk_pixel(16'd0, 16'd0, 16'd0, 16'd0),
                   mk_pixel(16'd1, 16'd255, 16'd255, 16'd255));
        push_pixel(mk_pixel(16'd1, 16'd255, 16'd0, 16'd0),
                   mk_pixel(16'd1, 16'd0, 16'd255, 16'd0));
    endtask

    task automatic test_blend_16bit;
        apply_setting(1'b1, 1'b1);
        push_pixel(mk_pixel(16'd30000, 16'd100, 16'd200, 16'd300),
                   mk_pixel(16'd0, 16'd32768, 16'd32768, 16'd32768));
        push_pixel(mk_pixel(16'd16384, 16'd1, 16'd2, 16'd3),
                   mk_pixel(16'd32768, 16'd32000, 16'd5, 16'd12345));
        push_pixel(mk_pixel(16'd0, 16'd999, 16'd999, 16'd999),
                   mk_pixel(16'd12345, 16'd20000, 16'd10000, 16'd5000));
        push_pixel(mk_pixel(16'd16384, 16'd32768, 16'd0, 16'd16384),
                   mk_pixel(16'd16384, 16'd0, 16'd32768, 16'd16384));
        push_pixel(mk_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff),
                   mk_pixel(16'hffff, 16'h8001, 16'd0, 16'h7fff));
        push_pixel(mk_pixel(16'd0, 16'd0, 16'd0, 16'd0),
                   mk_pixel(16'd1, 16'd32768, 16'd32767, 16'd1));
        push_pixel(mk_pixel(16'd1, 16'd32768, 16'd0, 16'd0),
                   mk_pixel(16'd1, 16'd0, 16'd32768, 16'h5555));
    endtask

    task automatic random_phase(input logic mode16, input logic blend, input int pct);
        int n;
        apply_setting(mode16, blend);
        idle_pct = pct;
        for (n = 0; n < PHASE_ITEMS; n++)
            push_pixel(rand_pixel(mode16), rand_pixel(mode16));
    endtask

    task automatic test_random_phases;
        random_phase(1'b1, 1'b1, 30);
        random_phase(1'b0, 1'b1, 40);
        random_phase(1'b1, 1'b0, 20);
        random_phase(1'b0, 1'b0, 35);
        // full rate on both channels to the end
        random_phase(1'b1, 1'b1, 0);
    endtask

    always @(negedge i_clk) begin
        if (idle_pct == 0) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct / 2) begin
            ready_hold = $urandom_range(1, 13) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pixel want;
        t_pixel got;
        logic   bad;
        int     k;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = mk_pixel(o_res_alpha, o_res_red, o_res_green, o_res_blue);
            if (composited_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: a=%h r=%h g=%h b=%h",
                             got[LANE_A], got[LANE_R], got[LANE_G], got[LANE_B]);
            end else begin
                want = composited_q.pop_front();
                pixels_checked++;
                bad = 1'b0;
                for (k = 0; k < 4; k++)
                    if (got[k] !== want[k])
                        bad = 1'b1;
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at item %0d: expected a=%h r=%h g=%h b=%h, got a=%h r=%h g=%h b=%h",
                                 pixels_checked, want[LANE_A], want[LANE_R], want[LANE_G],
                                 want[LANE_B], got[LANE_A], got[LANE_R], got[LANE_G],
                                 got[LANE_B]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, composited_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_DEPTH_MODE;
        i_cfg_data    = 1'b0;
        i_in_valid    = 1'b0;
        i_src_alpha   = 16'd0;
        i_src_red     = 16'd0;
        i_src_green   = 16'd0;
        i_src_blue    = 16'd0;
        i_drawn_alpha = 16'd0;
        i_drawn_red   = 16'd0;
        i_drawn_green = 16'd0;
        i_drawn_blue  = 16'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        settings_run = 1;

        test_reset_defaults();
        test_spare_indexes();
        test_passthrough_16bit();
        test_blend_8bit();
        test_blend_16bit();
        test_random_phases();
        drain_pipeline();

        if (composited_q.size() != 0)
            mismatch_count += composited_q.size();
        $display("sent %0d pixel pairs and compared %0d composited pixels",
                 pixels_sent, pixels_checked);
        $display("covered %0d register settings in both depth modes, %0d mismatches",
                 settings_run, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
